FILE: rtl/core/fbc_pkg.sv
package fbc_pkg;

    // Number of clip planes, one cell each
    localparam int NUM_PLANES  = 6;
    // Width of normal components and box coordinates
    localparam int COORD_BITS  = 16;
    // Plane offset in product scale
    localparam int OFFSET_BITS = 2 * COORD_BITS + 2;
    // Width of the plane slot field
    localparam int SLOT_BITS   = 3;
    // One normal component times one coordinate
    localparam int PROD_BITS   = 2 * COORD_BITS;
    // Three products plus the offset, with headroom
    localparam int SUM_BITS    = OFFSET_BITS + 2;

    typedef enum logic
    {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } req_type_t;

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [OFFSET_BITS-1:0] offset_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;

    // One transaction as it travels down the chain of plane cells
    typedef struct packed
    {
        req_type_t              kind;
        logic [SLOT_BITS-1:0]   index;
        coord_t                 a;
        coord_t                 b;
        coord_t                 c;
        offset_t                d;
        coord_t                 min_x;
        coord_t                 min_y;
        coord_t                 min_z;
        coord_t                 max_x;
        coord_t                 max_y;
        coord_t                 max_z;
        logic                   visible;
    } item_t;

endpackage

FILE: rtl/core/fbc_req_if.sv
interface fbc_req_if
    import fbc_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [SLOT_BITS-1:0]          plane_index;
    logic signed [COORD_BITS-1:0]  plane_a;
    logic signed [COORD_BITS-1:0]  plane_b;
    logic signed [COORD_BITS-1:0]  plane_c;
    logic signed [OFFSET_BITS-1:0] plane_d;
    logic signed [COORD_BITS-1:0]  min_x;
    logic signed [COORD_BITS-1:0]  min_y;
    logic signed [COORD_BITS-1:0]  min_z;
    logic signed [COORD_BITS-1:0]  max_x;
    logic signed [COORD_BITS-1:0]  max_y;
    logic signed [COORD_BITS-1:0]  max_z;

    modport source
    (
        output valid, req_type, plane_index, plane_a, plane_b, plane_c, plane_d,
               min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, plane_index, plane_a, plane_b, plane_c, plane_d,
               min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

FILE: rtl/core/fbc_rsp_if.sv
interface fbc_rsp_if;
    logic valid;
    logic ready;
    logic visible;

    modport source
    (
        output valid, visible,
        input  ready
    );

    modport sink
    (
        input  valid, visible,
        output ready
    );
endinterface

FILE: rtl/core/fbc_cell.sv
module fbc_cell
    import fbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [SLOT_BITS-1:0] cell_idx,
    input  logic                 in_valid,
    input  item_t                in_item,
    output logic                 out_valid,
    output item_t                out_item
);

    coord_t  a_reg, a_next;
    coord_t  b_reg, b_next;
    coord_t  c_reg, c_next;
    offset_t d_reg, d_next;

    logic    mid_valid_reg;
    item_t   mid_item_reg;
    prod_t   px_reg, py_reg, pz_reg;
    prod_t   px_next, py_next, pz_next;

    logic    out_valid_reg;
    item_t   out_item_reg, out_item_next;

    coord_t  sel_x, sel_y, sel_z;
    sum_t    dist_sum;
    logic    load_hit;

    // Pick the corner per axis that maximizes the distance, then multiply
    always_comb
    begin
        if (a_reg[COORD_BITS-1])
            sel_x = (in_item.min_x < in_item.max_x) ? in_item.min_x : in_item.max_x;
        else
            sel_x = (in_item.min_x > in_item.max_x) ? in_item.min_x : in_item.max_x;
        if (b_reg[COORD_BITS-1])
            sel_y = (in_item.min_y < in_item.max_y) ? in_item.min_y : in_item.max_y;
        else
            sel_y = (in_item.min_y > in_item.max_y) ? in_item.min_y : in_item.max_y;
        if (c_reg[COORD_BITS-1])
            sel_z = (in_item.min_z < in_item.max_z) ? in_item.min_z : in_item.max_z;
        else
            sel_z = (in_item.min_z > in_item.max_z) ? in_item.min_z : in_item.max_z;

        px_next = PROD_BITS'(a_reg) * PROD_BITS'(sel_x);
        py_next = PROD_BITS'(b_reg) * PROD_BITS'(sel_y);
        pz_next = PROD_BITS'(c_reg) * PROD_BITS'(sel_z);
    end

    // Capture a plane load addressed to this cell
    always_comb
    begin
        load_hit = adv && in_valid && (in_item.kind == REQ_LOAD)
                   && (in_item.index == cell_idx);
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (load_hit)
        begin
            a_next = in_item.a;
            b_next = in_item.b;
            c_next = in_item.c;
            d_next = in_item.d;
        end
    end

    // Sum the products with the offset and drop visibility if not above zero
    always_comb
    begin
        dist_sum = SUM_BITS'(px_reg) + SUM_BITS'(py_reg) + SUM_BITS'(pz_reg)
                   + SUM_BITS'(d_reg);
        out_item_next = mid_item_reg;
        if (mid_item_reg.kind == REQ_TEST)
            out_item_next.visible = mid_item_reg.visible
                                    && !dist_sum[SUM_BITS-1] && (|dist_sum);
    end

    // Plane store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid_item_reg <= in_item;
            px_reg       <= px_next;
            py_reg       <= py_next;
            pz_reg       <= pz_next;
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/core/frustum_box_cull.sv
// Axis-aligned box culling against NUM_PLANES clip planes. Each transaction on
// req either loads one plane (req_type 0; slots at or above NUM_PLANES are
// ignored) or tests a box (req_type 1), which yields exactly one transaction
// on rsp with visible = 0 when some plane sees all eight corners at a
// distance not above zero. Loads yield nothing. All planes reset to zero, so
// every box is rejected until the planes are loaded. The planes sit in a
// chain of cells, one per plane, and every transaction walks the chain in
// order, so a load only affects tests issued after it. One transaction is
// taken per clock; a test passes through a multiply stage and a sum and
// compare stage in every cell, then the output register, on its way to
// rsp.valid. A stalled rsp holds the whole chain.
module frustum_box_cull
    import fbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fbc_req_if.sink    req,
    fbc_rsp_if.source  rsp
);

    logic  adv;
    logic  chain_valid [NUM_PLANES+1];
    item_t chain_item  [NUM_PLANES+1];

    logic  rsp_valid_reg;
    logic  visible_reg;

    // Move the chain whenever the output register is free or being drained
    assign adv       = !rsp_valid_reg || rsp.ready;
    assign req.ready = adv;

    // Feed the head of the chain
    always_comb
    begin
        chain_valid[0]        = req.valid && adv;
        chain_item[0].kind    = req_type_t'(req.req_type);
        chain_item[0].index   = req.plane_index;
        chain_item[0].a       = req.plane_a;
        chain_item[0].b       = req.plane_b;
        chain_item[0].c       = req.plane_c;
        chain_item[0].d       = req.plane_d;
        chain_item[0].min_x   = req.min_x;
        chain_item[0].min_y   = req.min_y;
        chain_item[0].min_z   = req.min_z;
        chain_item[0].max_x   = req.max_x;
        chain_item[0].max_y   = req.max_y;
        chain_item[0].max_z   = req.max_z;
        chain_item[0].visible = 1'b1;
    end

    genvar i;
    generate
        for (i = 0; i < NUM_PLANES; i++)
        begin : g_cell
            fbc_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .cell_idx (SLOT_BITS'(i)),
                .in_valid (chain_valid[i]),
                .in_item  (chain_item[i]),
                .out_valid(chain_valid[i+1]),
                .out_item (chain_item[i+1])
            );
        end
    endgenerate

    // Output register: only tests produce a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= chain_valid[NUM_PLANES]
                             && (chain_item[NUM_PLANES].kind == REQ_TEST);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            visible_reg <= chain_item[NUM_PLANES].visible;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.visible = visible_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fbc_pkg::*;

    localparam int RANDOM_ITEMS = 530;
    localparam int CALM_START   = 150;
    localparam int CALM_STOP    = 400;
    localparam int DRAIN_CYCLES = 4 * NUM_PLANES + 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fbc_req_if req_if ();
    fbc_rsp_if rsp_if ();

    frustum_box_cull i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Plane store as the block should hold it
    coord_t  norm_a [NUM_PLANES];
    coord_t  norm_b [NUM_PLANES];
    coord_t  norm_c [NUM_PLANES];
    offset_t offset [NUM_PLANES];

    item_t       pending_items [$];
    bit          visible_due [$];
    item_t       on_bus;
    int unsigned cycle_no;
    int          fault_count;
    bit          calm;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    assign calm = (cycle_no >= CALM_START) && (cycle_no < CALM_STOP);

    // Larger of k*lo and k*hi: the corner on one axis farthest along the normal
    function automatic longint signed axis_peak(longint signed k, longint signed lo,
                                                longint signed hi);
        longint signed p;
        longint signed q;
        p = k * lo;
        q = k * hi;
        return (p > q) ? p : q;
    endfunction

    // Visible unless some plane has all eight corners at distance <= 0
    function automatic bit box_visible(item_t t);
        longint signed peak;
        bit            seen;
        seen = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            peak = axis_peak(norm_a[i], t.min_x, t.max_x)
                 + axis_peak(norm_b[i], t.min_y, t.max_y)
                 + axis_peak(norm_c[i], t.min_z, t.max_z)
                 + longint'(offset[i]);
            if (peak <= 0)
                seen = 1'b0;
        end
        return seen;
    endfunction

    // Update the plane store or queue the expected visibility
    function automatic void take_transaction(item_t t);
        if (t.kind == REQ_LOAD)
        begin
            if (t.index < NUM_PLANES)
            begin
                norm_a[t.index] = t.a;
                norm_b[t.index] = t.b;
                norm_c[t.index] = t.c;
                offset[t.index] = t.d;
            end
        end
        else
        begin
            visible_due.push_back(box_visible(t));
        end
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic offset_t any_offset();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return offset_t'(raw[OFFSET_BITS-1:0]);
    endfunction

    // Plane load; box fields carry noise that the block must ignore
    task automatic plan_load(int idx, int a, int b, int c, offset_t d);
        item_t t;
        t.kind    = REQ_LOAD;
        t.index   = idx[SLOT_BITS-1:0];
        t.a       = coord_t'(a);
        t.b       = coord_t'(b);
        t.c       = coord_t'(c);
        t.d       = d;
        t.min_x   = any_coord();
        t.min_y   = any_coord();
        t.min_z   = any_coord();
        t.max_x   = any_coord();
        t.max_y   = any_coord();
        t.max_z   = any_coord();
        t.visible = 1'b0;
        pending_items.push_back(t);
    endtask

    // Box test; plane fields carry noise that the block must ignore
    task automatic plan_test(int x0, int y0, int z0, int x1, int y1, int z1);
        item_t t;
        t.kind    = REQ_TEST;
        t.index   = SLOT_BITS'($urandom);
        t.a       = any_coord();
        t.b       = any_coord();
        t.c       = any_coord();
        t.d       = any_offset();
        t.min_x   = coord_t'(x0);
        t.min_y   = coord_t'(y0);
        t.min_z   = coord_t'(z0);
        t.max_x   = coord_t'(x1);
        t.max_y   = coord_t'(y1);
        t.max_z   = coord_t'(z1);
        t.visible = 1'b0;
        pending_items.push_back(t);
    endtask

    // Load a full set of sensible planes, mostly facing inward
    task automatic plan_frustum();
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            plan_load(i, $urandom_range(1023) - 512, $urandom_range(1023) - 512,
                      $urandom_range(1023) - 512,
                      offset_t'(int'($urandom_range(1 << 25) - (1 << 21))));
        end
    endtask

    task automatic plan_random_test();
        int cx;
        int cy;
        int cz;
        int ex;
        int ey;
        int ez;
        if ($urandom_range(99) < 75)
        begin
            cx = $urandom_range(8000) - 4000;
            cy = $urandom_range(8000) - 4000;
            cz = $urandom_range(8000) - 4000;
            ex = $urandom_range(500);
            ey = $urandom_range(500);
            ez = $urandom_range(500);
            if ($urandom_range(9) == 0)
                plan_test(cx, cy, cz, cx, cy, cz);
            else
                plan_test(cx - ex, cy - ey, cz - ez, cx + ex, cy + ey, cz + ez);
        end
        else
        begin
            plan_test(any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord());
        end
    endtask

    // Driver: advance to the next transaction once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        item_t nxt;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (req_if.valid)
                take_transaction(on_bus);
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 10))
            begin
                nxt = pending_items.pop_front();
                on_bus             <= nxt;
                req_if.valid       <= 1'b1;
                req_if.req_type    <= nxt.kind;
                req_if.plane_index <= nxt.index;
                req_if.plane_a     <= nxt.a;
                req_if.plane_b     <= nxt.b;
                req_if.plane_c     <= nxt.c;
                req_if.plane_d     <= nxt.d;
                req_if.min_x       <= nxt.min_x;
                req_if.min_y       <= nxt.min_y;
                req_if.min_z       <= nxt.min_z;
                req_if.max_x       <= nxt.max_x;
                req_if.max_y       <= nxt.max_y;
                req_if.max_z       <= nxt.max_z;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, check each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (visible_due.size() == 0)
                begin
                    $error("visible: no result expected, actual %0d", rsp_if.visible);
                    fault_count++;
                end
                else
                begin
                    want = visible_due.pop_front();
                    if (rsp_if.visible !== want)
                    begin
                        $error("visible: expected %0d, actual %0d", want, rsp_if.visible);
                        fault_count++;
                    end
                end
            end
            rsp_if.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // Stimulus and end of run
    initial
    begin
        int random_count;

        req_if.valid       = 1'b0;
        req_if.req_type    = 1'b0;
        req_if.plane_index = '0;
        req_if.plane_a     = '0;
        req_if.plane_b     = '0;
        req_if.plane_c     = '0;
        req_if.plane_d     = '0;
        req_if.min_x       = '0;
        req_if.min_y       = '0;
        req_if.min_z       = '0;
        req_if.max_x       = '0;
        req_if.max_y       = '0;
        req_if.max_z       = '0;
        rsp_if.ready       = 1'b0;
        cycle_no           = 0;
        fault_count        = 0;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            norm_a[i] = '0;
            norm_b[i] = '0;
            norm_c[i] = '0;
            offset[i] = '0;
        end

        // Cleared store rejects everything
        plan_test(0, 0, 0, 0, 0, 0);
        // Cube of half-width 1000 around the origin
        plan_load(0,  1,  0,  0, offset_t'(1000));
        plan_load(1, -1,  0,  0, offset_t'(1000));
        plan_load(2,  0,  1,  0, offset_t'(1000));
        plan_load(3,  0, -1,  0, offset_t'(1000));
        plan_load(4,  0,  0,  1, offset_t'(1000));
        plan_load(5,  0,  0, -1, offset_t'(1000));
        plan_test(-10, -10, -10, 10, 10, 10);
        plan_test(2000, 0, 0, 3000, 10, 10);
        plan_test(500, -5, -5, 1500, 5, 5);
        plan_test(5, 5, 5, 5, 5, 5);
        // Point exactly on a plane sits at distance zero
        plan_test(1000, 0, 0, 1000, 0, 0);
        // Min above max on every axis
        plan_test(10, 10, 10, -10, -10, -10);
        plan_test(-32768, -32768, -32768, 32767, 32767, 32767);
        // Slots out of range leave the store alone
        plan_load(6, 0, 0, 0, offset_t'(0));
        plan_load(7, 0, 0, 0, offset_t'(0));
        plan_test(-10, -10, -10, 10, 10, 10);
        // Extreme plane values
        plan_load(5, -32768, -32768, -32768, offset_t'({1'b1, {(OFFSET_BITS-1){1'b0}}}));
        plan_test(-32768, -32768, -32768, -32768, -32768, -32768);
        plan_test(-32768, -32768, -32768, 32767, 32767, 32767);
        plan_load(5, 32767, 32767, 32767, offset_t'({1'b0, {(OFFSET_BITS-1){1'b1}}}));
        plan_test(-32768, -32768, -32768, 32767, 32767, 32767);
        plan_load(5, 0, 0, -1, offset_t'(1000));

        // Random frustums followed by bursts of tests, with stray loads
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(1) == 0)
            begin
                plan_frustum();
                random_count += NUM_PLANES;
            end
            repeat ($urandom_range(40, 20))
            begin
                if ($urandom_range(99) < 8)
                    plan_load($urandom_range(7), any_coord(), any_coord(), any_coord(),
                              ($urandom_range(3) == 0) ? any_offset()
                              : offset_t'(int'($urandom_range(1 << 30) - (1 << 27))));
                else
                    plan_random_test();
                random_count++;
            end
        end

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain
        while (pending_items.size() != 0 || req_if.valid)
            @(posedge clk);
        while (visible_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("frustum_box_cull verification clean");
        else
            $display("frustum_box_cull verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("frustum_box_cull verification failed");
        $finish;
    end

endmodule
